>>> rtl/core/hkar_pkg.sv
package hkar_pkg;

    localparam int COUNT_BITS    = 8;
    localparam int OUT_TIME_BITS = 32;
    localparam int DELTA_BITS    = 16;
    localparam int ACTION_BITS   = 4;
    localparam int CMD_BITS      = 2;

    typedef logic [CMD_BITS-1:0] t_cmd;

    localparam t_cmd CMD_PRESS   = 2'd0;
    localparam t_cmd CMD_RELEASE = 2'd1;
    localparam t_cmd CMD_HELD    = 2'd2;
    localparam t_cmd CMD_TICK    = 2'd3;

    localparam t_cmd KIND_HELD   = 2'd2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

endpackage

>>> rtl/core/hkar_ram.sv
module hkar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/hkar_upd.sv
module hkar_upd
    import hkar_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  t_cmd                      i_cmd,
    input  logic [COUNT_BITS-1:0]     i_cnt,
    input  logic                      i_held,
    input  logic [TIME_BITS-1:0]      i_htime,
    input  logic [TIME_BITS-1:0]      i_since,
    input  logic [DELTA_BITS-1:0]     i_delta,
    input  logic [OUT_TIME_BITS-1:0]  i_interval,
    output logic [COUNT_BITS-1:0]     o_cnt,
    output logic                      o_held,
    output logic [TIME_BITS-1:0]      o_htime,
    output logic [TIME_BITS-1:0]      o_since,
    output logic                      o_due
);

    localparam int CW = (TIME_BITS > OUT_TIME_BITS) ? TIME_BITS : OUT_TIME_BITS;
    localparam int SW = ((TIME_BITS > DELTA_BITS) ? TIME_BITS : DELTA_BITS) + 1;

    logic [SW-1:0]        sum_h;
    logic [SW-1:0]        sum_s;
    logic [TIME_BITS-1:0] sat_h;
    logic [TIME_BITS-1:0] sat_s;
    logic                 due;

    assign sum_h = SW'(i_htime) + SW'(i_delta);
    assign sum_s = SW'(i_since) + SW'(i_delta);
    assign sat_h = (sum_h[SW-1:TIME_BITS] != '0) ? '1 : sum_h[TIME_BITS-1:0];
    assign sat_s = (sum_s[SW-1:TIME_BITS] != '0) ? '1 : sum_s[TIME_BITS-1:0];
    assign due   = CW'(sat_s) >= CW'(i_interval);

    always_comb begin
        o_cnt   = i_cnt;
        o_held  = i_held;
        o_htime = i_htime;
        o_since = i_since;
        o_due   = 1'b0;
        case (i_cmd)
            CMD_PRESS: begin
                if (i_cnt != COUNT_MAX) begin
                    o_cnt = i_cnt + COUNT_BITS'(1);
                    if (i_cnt == '0) begin
                        o_held  = 1'b1;
                        o_htime = '0;
                        o_since = '0;
                    end
                end
            end
            CMD_RELEASE: begin
                if (i_cnt > COUNT_BITS'(1)) begin
                    o_cnt = i_cnt - COUNT_BITS'(1);
                end else begin
                    o_cnt   = '0;
                    o_held  = 1'b0;
                    o_htime = '0;
                    o_since = '0;
                end
            end
            CMD_TICK: begin
                o_htime = sat_h;
                o_since = due ? '0 : sat_s;
                o_due   = due;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/core/held_key_auto_repeat.sv
// Typematic auto-repeat tracker.
// Input channel (i_in_valid/o_in_ready): cmd press, release, outside held
// event or time tick, with action index and delta. Output channel
// (o_out_valid/i_out_ready): result items kind, action, time, last flag.
// Config channel (i_cfg_valid/o_cfg_ready): repeat interval, always ready.
// Press/release/held items: one echoed result, loaded into the output
// register from S_UPD once it is free; no new item is taken until S_IDLE.
// Tick: scans the per-action state memory one entry per cycle through a
// read-modify-write loop, then goes through S_FLUSH when a repeat result
// is still pending at the end of the scan.
// Each held result is kept one entry back so the final one carries last.
// A stalled receiver holds the output register; the scan waits on an entry
// that needs to push a result while the output is still full.
// Reset clears the per-entry valid bits, so all actions read as released
// with zero count and times; interval resets to 0. No clearing pass.
module held_key_auto_repeat
    import hkar_pkg::*;
#(
    parameter int NUM_ACTIONS = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [OUT_TIME_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [CMD_BITS-1:0]      i_cmd,
    input  logic [ACTION_BITS-1:0]   i_action,
    input  logic [DELTA_BITS-1:0]    i_delta,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [CMD_BITS-1:0]      o_kind,
    output logic [ACTION_BITS-1:0]   o_which_action,
    output logic [OUT_TIME_BITS-1:0] o_time_value,
    output logic                     o_last
);

    localparam int AW = $clog2(NUM_ACTIONS);
    localparam int EW = COUNT_BITS + 1 + 2 * TIME_BITS;
    localparam logic [AW-1:0] IDX_LAST = AW'(NUM_ACTIONS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_UPD   = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]               r_state, n_state;
    t_cmd                     r_cmd, n_cmd;
    logic [ACTION_BITS-1:0]   r_act, n_act;
    logic [DELTA_BITS-1:0]    r_delta, n_delta;
    logic [AW-1:0]            r_idx, n_idx;
    logic                     r_rd_ok, n_rd_ok;
    logic [NUM_ACTIONS-1:0]   r_vld;
    logic [OUT_TIME_BITS-1:0] r_interval;
    logic                     r_pend_v, n_pend_v;
    logic [ACTION_BITS-1:0]   r_pend_act, n_pend_act;
    logic [OUT_TIME_BITS-1:0] r_pend_time, n_pend_time;
    logic                     r_out_valid;
    t_cmd                     r_out_kind;
    logic [ACTION_BITS-1:0]   r_out_act;
    logic [OUT_TIME_BITS-1:0] r_out_time;
    logic                     r_out_last;

    logic                     ram_we, ram_re;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [EW-1:0]            ram_wdata, ram_rdata, ent;

    logic                     out_free, out_load, out_last;
    t_cmd                     out_kind;
    logic [ACTION_BITS-1:0]   out_act;
    logic [OUT_TIME_BITS-1:0] out_time;

    logic                     in_range, act_in_range;
    logic [COUNT_BITS-1:0]    u_cnt;
    logic                     u_held;
    logic [TIME_BITS-1:0]     u_htime, u_since;
    logic                     u_due;

    hkar_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_ACTIONS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ent = r_rd_ok ? ram_rdata : '0;

    hkar_upd #(
        .TIME_BITS (TIME_BITS)
    ) u_upd (
        .i_cmd      (r_cmd),
        .i_cnt      (ent[EW-1 -: COUNT_BITS]),
        .i_held     (ent[2*TIME_BITS]),
        .i_htime    (ent[2*TIME_BITS-1 -: TIME_BITS]),
        .i_since    (ent[TIME_BITS-1:0]),
        .i_delta    (r_delta),
        .i_interval (r_interval),
        .o_cnt      (u_cnt),
        .o_held     (u_held),
        .o_htime    (u_htime),
        .o_since    (u_since),
        .o_due      (u_due)
    );

    assign ram_wdata    = {u_cnt, u_held, u_htime, u_since};
    assign in_range     = 32'(i_action) < NUM_ACTIONS;
    assign act_in_range = 32'(r_act) < NUM_ACTIONS;
    assign out_free     = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_act       = r_act;
        n_delta     = r_delta;
        n_idx       = r_idx;
        n_rd_ok     = r_rd_ok;
        n_pend_v    = r_pend_v;
        n_pend_act  = r_pend_act;
        n_pend_time = r_pend_time;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = r_idx;
        ram_raddr   = r_idx;
        out_load    = 1'b0;
        out_kind    = KIND_HELD;
        out_act     = r_pend_act;
        out_time    = r_pend_time;
        out_last    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_cmd;
                    n_act   = i_action;
                    n_delta = i_delta;
                    if (i_cmd == CMD_TICK) begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        n_idx     = '0;
                        n_rd_ok   = r_vld[0];
                        n_state   = S_SCAN;
                    end else begin
                        ram_re    = in_range;
                        ram_raddr = AW'(i_action);
                        n_rd_ok   = in_range ? r_vld[AW'(i_action)] : 1'b0;
                        n_state   = S_UPD;
                    end
                end
            end
            S_UPD: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    out_kind  = r_cmd;
                    out_act   = r_act;
                    out_time  = OUT_TIME_BITS'(r_delta);
                    out_last  = 1'b1;
                    ram_we    = act_in_range && (r_cmd != CMD_HELD);
                    ram_waddr = AW'(r_act);
                    n_state   = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!(ent[2*TIME_BITS] && u_due && r_pend_v && !out_free)) begin
                    if (ent[2*TIME_BITS]) begin
                        ram_we = 1'b1;
                        if (u_due) begin
                            out_load    = r_pend_v;
                            n_pend_v    = 1'b1;
                            n_pend_act  = ACTION_BITS'(r_idx);
                            n_pend_time = OUT_TIME_BITS'(u_htime);
                        end
                    end
                    if (r_idx == IDX_LAST) begin
                        n_state = n_pend_v ? S_FLUSH : S_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_idx + AW'(1);
                        n_idx     = r_idx + AW'(1);
                        n_rd_ok   = r_vld[r_idx + AW'(1)];
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_last = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_interval  <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_ok     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
            r_rd_ok  <= n_rd_ok;
            if (i_cfg_valid) begin
                r_interval <= i_cfg_data;
            end
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_act       <= n_act;
        r_delta     <= n_delta;
        r_idx       <= n_idx;
        r_pend_act  <= n_pend_act;
        r_pend_time <= n_pend_time;
        if (out_load) begin
            r_out_kind <= out_kind;
            r_out_act  <= out_act;
            r_out_time <= out_time;
            r_out_last <= out_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_which_action = r_out_act;
    assign o_time_value   = r_out_time;
    assign o_last         = r_out_last;

endmodule
